// ===== rtl/sbs_pkg.sv =====
`default_nettype none

package sbs_pkg;

    // default table size
    localparam int TABLE_DEPTH_DEF = 1024;

    // signed working width of the search interval bounds
    // holds -1024 up to 1024, the extremes of lo and hi over a search
    localparam int IDX_W = 12;

    // field widths of the stream words
    localparam int ENTRY_INDEX_W = 10;
    localparam int VALUE_W       = 32;
    localparam int LOWER_W       = 10;
    localparam int UPPER_W       = 11;
    localparam int S_DATA_W      = 96;
    localparam int M_DATA_W      = 8;

    // request kinds carried in s_tuser
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;   // start a search from the input word
        logic step;   // narrow the interval after a miss
        logic wr_en;  // store one table entry
    } sbs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic match;  // probed entry equals the key
        logic empty;  // interval selected this cycle is empty
    } sbs_stat_t;

endpackage

`default_nettype wire

// ===== rtl/sbs_datapath.sv =====
`default_nettype none

module sbs_datapath
    import sbs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire sbs_cmd_t                        cmd,
    output sbs_stat_t                            stat,
    input  wire logic [ENTRY_INDEX_W-1:0]        entry_index,
    input  wire logic signed [VALUE_W-1:0]       entry_value,
    input  wire logic signed [VALUE_W-1:0]       search_key,
    input  wire logic [LOWER_W-1:0]              lower_bound,
    input  wire logic signed [UPPER_W-1:0]       upper_bound
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int HI_MAX_INT = (TABLE_DEPTH - 1 > 1023) ? 1023 : TABLE_DEPTH - 1;
    localparam logic signed [IDX_W-1:0] HI_MAX = IDX_W'(HI_MAX_INT);
    localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);

    logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];

    logic signed [IDX_W-1:0]   lo_reg;
    logic signed [IDX_W-1:0]   hi_reg;
    logic signed [IDX_W-1:0]   mid_reg;
    logic signed [VALUE_W-1:0] key_reg;
    logic signed [VALUE_W-1:0] rd_reg;

    logic signed [IDX_W-1:0]   lo_in;
    logic signed [IDX_W-1:0]   hi_raw;
    logic signed [IDX_W-1:0]   hi_in;
    logic signed [IDX_W-1:0]   lo_step;
    logic signed [IDX_W-1:0]   hi_step;
    logic signed [IDX_W-1:0]   lo_next;
    logic signed [IDX_W-1:0]   hi_next;
    logic signed [IDX_W-1:0]   span;
    logic signed [IDX_W-1:0]   mid_next;
    logic                      key_above;
    logic                      wr_ok;
    logic [ADDR_W-1:0]         rd_addr;
    logic [ADDR_W-1:0]         wr_addr;

    // bounds of a new search, upper clamped to the last entry
    assign lo_in  = IDX_W'({2'b00, lower_bound});
    assign hi_raw = IDX_W'(upper_bound);
    assign hi_in  = (hi_raw > HI_MAX) ? HI_MAX : hi_raw;

    // compare of the probed entry with the key
    assign stat.match = (rd_reg == key_reg);
    assign key_above  = (rd_reg < key_reg);

    assign lo_step = key_above ? mid_reg + IDX_W'(1) : lo_reg;
    assign hi_step = key_above ? hi_reg : mid_reg - IDX_W'(1);

    assign lo_next = cmd.load ? lo_in : lo_step;
    assign hi_next = cmd.load ? hi_in : hi_step;

    // midpoint rounded down; only used while lo <= hi
    assign span       = hi_next - lo_next;
    assign mid_next   = lo_next + (span >>> 1);
    assign stat.empty = (lo_next > hi_next);

    assign rd_addr = ADDR_W'(unsigned'(mid_next));
    assign wr_addr = ADDR_W'(entry_index);
    assign wr_ok   = ({22'd0, entry_index} < DEPTH_W);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_ok)
        begin
            mem[wr_addr] <= entry_value;
        end
        if (cmd.load || cmd.step)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load || cmd.step)
        begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            mid_reg <= mid_next;
        end
        if (cmd.load)
        begin
            key_reg <= search_key;
        end
    end

    // rst_n kept for a uniform port list; datapath holds payload only
    logic unused_rst;
    assign unused_rst = rst_n;

endmodule

`default_nettype wire

// ===== rtl/sbs_ctrl.sv =====
`default_nettype none

module sbs_ctrl
    import sbs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   s_tvalid,
    output logic        s_tready,
    input  wire logic   req_type,
    output logic        m_tvalid,
    input  wire logic   m_tready,
    output logic        found,
    output sbs_cmd_t    cmd,
    input  wire sbs_stat_t stat
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_HOLD  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_found_reg;
    logic       out_found_next;
    logic       res_reg;
    logic       res_next;

    logic       accept;
    logic       slot_free;
    logic       done;
    logic       res;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign found     = out_found_reg;

    always_comb
    begin
        cmd            = '0;
        done           = 1'b0;
        res            = 1'b0;
        state_next     = state_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_found_next = out_found_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_WRITE)
                    begin
                        cmd.wr_en = 1'b1;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                        if (stat.empty)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_PROBE;
                        end
                    end
                end
            end
            ST_PROBE:
            begin
                if (stat.match)
                begin
                    done = 1'b1;
                    res  = 1'b1;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (stat.empty)
                    begin
                        done = 1'b1;
                    end
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (done)
        begin
            if (slot_free)
            begin
                out_valid_next = 1'b1;
                out_found_next = res;
                state_next     = ST_IDLE;
            end
            else
            begin
                res_next   = res;
                state_next = ST_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_found_reg <= out_found_next;
        res_reg       <= res_next;
    end

endmodule

`default_nettype wire

// ===== rtl/sorted_table_binary_search_core.sv =====
`default_nettype none

// binary search over a sorted table of signed 32-bit words
//
// s_* carries requests: s_tuser 0 writes entry_value at entry_index (no
// result word); s_tuser 1 searches for search_key in the inclusive index
// interval lower_bound..upper_bound and yields one result word on m_*
// with m_tdata[0] = found. an upper bound past the table is clamped to the
// last entry; an empty interval answers 0 at once.
// a write never drops s_tready. a search of p probes keeps s_tready low
// while it probes, one registered table read per cycle feeding the
// compare and the next midpoint; p is at most floor(log2(depth))+1, so 11
// at depth 1024. the result word and s_tready come back together after the
// last probe, so a new request can be taken while the result is shown. an
// empty interval needs no probe and drops s_tready only while its result
// waits for a full output register.
// the table keeps its contents across reset and must be written before it
// is searched; reset only idles the controller and drops any pending result.
// when the receiver stalls, the result sits in the output register and the
// next request is still taken; a search finishing into a full output
// register waits there until the word is taken.

module sorted_table_binary_search_core
    import sbs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // entry_index[9:0], entry_value[41:10], search_key[73:42],
    // lower_bound[83:74], upper_bound[94:84], zero pad[95]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // req_type[0]
    input  wire logic                s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // found[0], zero pad[7:1]
    output logic [M_DATA_W-1:0]      m_tdata
);

    sbs_cmd_t  cmd;
    sbs_stat_t stat;
    logic      found;

    logic [ENTRY_INDEX_W-1:0]  entry_index;
    logic signed [VALUE_W-1:0] entry_value;
    logic signed [VALUE_W-1:0] search_key;
    logic [LOWER_W-1:0]        lower_bound;
    logic signed [UPPER_W-1:0] upper_bound;
    logic                      pad_bit;

    // unpack the request word
    assign entry_index = s_tdata[9:0];
    assign entry_value = s_tdata[41:10];
    assign search_key  = s_tdata[73:42];
    assign lower_bound = s_tdata[83:74];
    assign upper_bound = s_tdata[94:84];
    assign pad_bit     = s_tdata[95];

    // result word, found in the low bit
    assign m_tdata = {{(M_DATA_W-1){pad_bit & 1'b0}}, found};

    sbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .found    (found),
        .cmd      (cmd),
        .stat     (stat)
    );

    sbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .search_key  (search_key),
        .lower_bound (lower_bound),
        .upper_bound (upper_bound)
    );

endmodule

`default_nettype wire
